@@ design/date_time_field_editor_top_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the date and time field editor
// ---------------------------------------------------------------------------
`ifndef DATE_TIME_FIELD_EDITOR_TOP_MACROS_SVH
`define DATE_TIME_FIELD_EDITOR_TOP_MACROS_SVH

// Check a condition at every clock edge outside reset
`define DTFE_CHECK(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a condition is followed by another in the next cycle
`define DTFE_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/dtfe_pkg.sv @@
// ---------------------------------------------------------------------------
// dtfe_pkg
// Types, constants and calendar helpers for the date and time field editor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dtfe_pkg;

  // Field select codes
  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;
  localparam logic [2:0] FIELD_SECOND = 3'd5;

  localparam logic [11:0] YEAR_MIN = 12'd2020;
  localparam logic [11:0] YEAR_MAX = 12'd2099;

  // Default working copy when the clock seed is not valid
  localparam logic [11:0] DEF_YEAR   = 12'd2026;
  localparam logic [3:0]  DEF_MONTH  = 4'd1;
  localparam logic [4:0]  DEF_DAY    = 5'd1;
  localparam logic [4:0]  DEF_HOUR   = 5'd0;
  localparam logic [5:0]  DEF_MINUTE = 6'd0;
  localparam logic [5:0]  DEF_SECOND = 6'd0;

  localparam logic [3:0] TPU_RESET = 4'd2;
  localparam logic [3:0] TPU_MAX   = 4'd8;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_STEP,
    ST_CLAMP,
    ST_DONE
  } dtfe_state_t;

  typedef struct packed {
    logic signed [5:0] steps;
    logic              button;
    logic              seed_ok;
    logic [11:0]       seed_year;
    logic [3:0]        seed_month;
    logic [4:0]        seed_day;
    logic [4:0]        seed_hour;
    logic [5:0]        seed_minute;
    logic [5:0]        seed_second;
  } dtfe_in_t;

  typedef struct packed {
    logic        editing;
    logic [2:0]  active_field_out;
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
    logic        commit;
  } dtfe_out_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } dtfe_date_t;

  // Control from the sequencer to the field unit
  typedef struct packed {
    logic [2:0] field;
    logic       up;
  } dtfe_step_ctl_t;

  // Leap test; year / 100 by reciprocal multiply, exact below 4096
  function automatic logic is_leap(input logic [11:0] year);
    logic [24:0] prod;
    logic [5:0]  quo;
    logic [11:0] rem;
    prod = {13'd0, year} * 25'd5243;
    quo  = prod[24:19];
    rem  = year - (({6'd0, quo} << 6) + ({6'd0, quo} << 5) + ({6'd0, quo} << 2));
    return (year[1:0] == 2'd0) && ((rem != 12'd0) || (quo[1:0] == 2'd0));
  endfunction

  // Days in a month; a month outside 1..12 counts as 31 days
  function automatic logic [4:0] month_days(input logic [11:0] year, input logic [3:0] month);
    logic [3:0] idx;
    idx = month - 4'd1;
    if ((month < 4'd1) || (month > 4'd12)) begin
      return 5'd31;
    end else if (month == 4'd2) begin
      return is_leap(year) ? 5'd29 : 5'd28;
    end else begin
      return MONTH_LEN[idx];
    end
  endfunction

  // Step a value by one and wrap it into lo .. lo+span-1
  function automatic logic [5:0] wrap_step(input logic [5:0] cur, input logic up,
                                           input logic [5:0] lo, input logic [5:0] span);
    logic signed [7:0] r;
    r = $signed({2'b00, cur}) + (up ? 8'sd1 : -8'sd1) - $signed({2'b00, lo});
    if (r < 8'sd0) begin
      r = r + $signed({2'b00, span});
    end else if (r >= $signed({2'b00, span})) begin
      r = r - $signed({2'b00, span});
    end
    r = r + $signed({2'b00, lo});
    return r[5:0];
  endfunction

endpackage

`default_nettype wire

@@ design/date_time_field_editor_top.sv @@
// ---------------------------------------------------------------------------
// date_time_field_editor_top
// Encoder and button driven editor for a date and time working copy.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake         | beat
//  in       | input     | in_valid/in_stall | dtfe_in_t: ticks, press, seed
//  out      | output    | out_valid/out_stall | dtfe_out_t: working copy
//  cfg      | input     | cfg_valid/cfg_ready | ticks_per_unit (4 bits)
//
//  An item makes its unit changes one after another (at most 39 of them),
//  then waits out any output stall in the done state; each unit change is
//  one pass of the shared field unit followed by a day clamp.
//  Synchronous reset restores 2026-01-01 00:00:00, field year, no session.
//  A result waits in the output register while the next item is accepted.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "date_time_field_editor_top_macros.svh"

module date_time_field_editor_top (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire dtfe_pkg::dtfe_in_t in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dtfe_pkg::dtfe_out_t out_data,
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic [3:0]     cfg_data
);
  import dtfe_pkg::*;

  dtfe_state_t       state, state_next;
  logic              editing, editing_next;
  logic [2:0]        field, field_next;
  logic signed [6:0] acc, acc_next;
  dtfe_date_t        date, date_next;
  logic [3:0]        tpu;
  logic              rot, rot_next;
  logic              out_valid_next;
  dtfe_out_t         out_data_next;

  // Item payload held for the whole item
  logic              button_q, seed_ok_q;
  dtfe_date_t        seed_q;

  logic              accept, out_free;
  logic [3:0]        tval;
  logic signed [6:0] t_s;
  logic              pos, neg, step_go;
  dtfe_step_ctl_t    ctl;
  dtfe_date_t        step_date;
  logic [4:0]        dim;
  logic              commit_b;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;

  // Effective ticks per unit, limited to 1..8
  always_comb begin
    if (tpu == 4'd0) begin
      tval = 4'd1;
    end else if (tpu > TPU_MAX) begin
      tval = TPU_MAX;
    end else begin
      tval = tpu;
    end
  end

  assign t_s     = $signed({3'b000, tval});
  assign pos     = (acc >= t_s);
  assign neg     = ((acc + t_s) <= 7'sd0);
  assign step_go = rot && (pos || neg);
  assign ctl     = '{field: field, up: pos};
  assign dim     = month_days(date.year, date.month);

  dtfe_step u_step (
    .ctl (ctl),
    .cur (date),
    .nxt (step_date)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_STEP;
        end
      end
      ST_STEP: begin
        state_next = step_go ? ST_CLAMP : ST_DONE;
      end
      ST_CLAMP: begin
        state_next = ST_STEP;
      end
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Datapath and result
  always_comb begin
    editing_next   = editing;
    field_next     = field;
    acc_next       = acc;
    date_next      = date;
    rot_next       = rot;
    commit_b       = 1'b0;
    out_valid_next = out_valid && out_stall;
    out_data_next  = out_data;
    case (state)
      ST_IDLE: begin
        // Accumulate ticks only inside a session
        if (accept) begin
          rot_next = (in_data.steps != 6'sd0) && editing;
          if ((in_data.steps != 6'sd0) && editing) begin
            acc_next = acc + {in_data.steps[5], in_data.steps};
          end
        end
      end
      ST_STEP: begin
        if (step_go) begin
          date_next = step_date;
          acc_next  = pos ? (acc - t_s) : (acc + t_s);
        end
      end
      ST_CLAMP: begin
        if (date.day > dim) begin
          date_next.day = dim;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          // Apply the press after rotation
          if (button_q) begin
            if (!editing) begin
              if (seed_ok_q) begin
                date_next = seed_q;
              end else begin
                date_next = '{year: DEF_YEAR, month: DEF_MONTH, day: DEF_DAY,
                              hour: DEF_HOUR, minute: DEF_MINUTE, second: DEF_SECOND};
              end
              field_next   = FIELD_YEAR;
              acc_next     = 7'sd0;
              editing_next = 1'b1;
            end else if (field >= FIELD_SECOND) begin
              commit_b     = 1'b1;
              editing_next = 1'b0;
            end else begin
              field_next = field + 3'd1;
              acc_next   = 7'sd0;
            end
          end
          out_valid_next = 1'b1;
          out_data_next  = '{editing: editing_next, active_field_out: field_next,
                             year_out: date_next.year, month_out: date_next.month,
                             day_out: date_next.day, hour_out: date_next.hour,
                             minute_out: date_next.minute, second_out: date_next.second,
                             commit: commit_b};
        end
      end
      default: begin
        rot_next = 1'b0;
      end
    endcase
  end

  // Control and working copy registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      editing   <= 1'b0;
      field     <= FIELD_YEAR;
      acc       <= 7'sd0;
      date      <= '{year: DEF_YEAR, month: DEF_MONTH, day: DEF_DAY,
                     hour: DEF_HOUR, minute: DEF_MINUTE, second: DEF_SECOND};
      tpu       <= TPU_RESET;
      rot       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      editing   <= editing_next;
      field     <= field_next;
      acc       <= acc_next;
      date      <= date_next;
      rot       <= rot_next;
      out_valid <= out_valid_next;
      if (cfg_valid && cfg_ready) begin
        tpu <= cfg_data;
      end
    end
  end

  // Hold the item payload and the result beat
  always_ff @(posedge clk) begin
    out_data <= out_data_next;
    if (accept) begin
      button_q  <= in_data.button;
      seed_ok_q <= in_data.seed_ok;
      seed_q    <= '{year: in_data.seed_year, month: in_data.seed_month,
                     day: in_data.seed_day, hour: in_data.seed_hour,
                     minute: in_data.seed_minute, second: in_data.seed_second};
    end
  end

  // Checks
  `DTFE_CHECK(a_acc_bounded, (state != ST_IDLE) || ((acc <= 7'sd7) && (acc >= -7'sd7)), "tick accumulator out of range when idle")
  `DTFE_CHECK(a_field_range, field <= FIELD_SECOND, "active field beyond second")
  `DTFE_CHECK(a_commit_ends, !(out_valid && out_data.commit) || !out_data.editing, "commit beat still shows editing")
  `DTFE_NEXT(a_accept_busy, accept, state != ST_IDLE, "sequencer idle after an accepted beat")

endmodule

`default_nettype wire

@@ design/dtfe_step.sv @@
// ---------------------------------------------------------------------------
// dtfe_step
// Shared field unit: moves the selected field of the working copy by one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dtfe_step (
  input  wire dtfe_pkg::dtfe_step_ctl_t ctl,
  input  wire dtfe_pkg::dtfe_date_t     cur,
  output dtfe_pkg::dtfe_date_t          nxt
);
  import dtfe_pkg::*;

  logic signed [13:0] year_sum;
  logic [4:0]         dim;
  logic [5:0]         wrapped;

  // Year clamps, every other field wraps
  always_comb begin
    nxt      = cur;
    year_sum = $signed({2'b00, cur.year}) + (ctl.up ? 14'sd1 : -14'sd1);
    dim      = month_days(cur.year, cur.month);
    wrapped  = 6'd0;
    case (ctl.field)
      FIELD_YEAR: begin
        if (year_sum < $signed({2'b00, YEAR_MIN})) begin
          nxt.year = YEAR_MIN;
        end else if (year_sum > $signed({2'b00, YEAR_MAX})) begin
          nxt.year = YEAR_MAX;
        end else begin
          nxt.year = year_sum[11:0];
        end
      end
      FIELD_MONTH: begin
        wrapped   = wrap_step({2'b00, cur.month}, ctl.up, 6'd1, 6'd12);
        nxt.month = wrapped[3:0];
      end
      FIELD_DAY: begin
        wrapped = wrap_step({1'b0, cur.day}, ctl.up, 6'd1, {1'b0, dim});
        nxt.day = wrapped[4:0];
      end
      FIELD_HOUR: begin
        wrapped  = wrap_step({1'b0, cur.hour}, ctl.up, 6'd0, 6'd24);
        nxt.hour = wrapped[4:0];
      end
      FIELD_MINUTE: begin
        nxt.minute = wrap_step(cur.minute, ctl.up, 6'd0, 6'd60);
      end
      FIELD_SECOND: begin
        nxt.second = wrap_step(cur.second, ctl.up, 6'd0, 6'd60);
      end
      default: begin
        nxt = cur;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ bench/tb_date_time_field_editor_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_date_time_field_editor_top
// Self-checking bench for the encoder-driven date and time field editor.
// A behavioural copy of the editor predicts every result beat from the
// accepted input beats. Each result is checked field by field against the
// oldest prediction. Stimulus is a short directed walk through sessions,
// then random edit sessions under several tick settings and idling mixes,
// then a long output hold-off that backs the block up to its input.
// ---------------------------------------------------------------------------

module tb_date_time_field_editor_top;
  import dtfe_pkg::*;

  localparam int DRAIN_CYCLES  = 100;         // beyond the worst item latency
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 325;
  localparam longint LIMIT_NS  = 64'd20_000_000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  dtfe_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  dtfe_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  // Predictor state
  logic [3:0]  tpu_setting;
  logic        edit_on;
  logic [2:0]  cur_field;
  int          tick_sum;
  dtfe_date_t  work;

  dtfe_out_t   expected_edits[$];

  int send_idle_pct;
  int recv_idle_pct;
  int hold_req;
  int hold_left;
  int fails;
  int items_sent;
  int results_checked;
  int commits_seen;
  int input_held_cycles;

  date_time_field_editor_top uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // -------------------------------------------------------------------------
  // Calendar arithmetic of the predictor
  // -------------------------------------------------------------------------
  function automatic bit leap_year(input logic [11:0] y);
    int yi;
    yi = y;
    return ((yi % 4 == 0) && (yi % 100 != 0)) || (yi % 400 == 0);
  endfunction

  function automatic int days_for_month(input logic [11:0] y, input logic [3:0] m);
    if (m < 4'd1 || m > 4'd12) return 31;
    if (m == 4'd2) return leap_year(y) ? 29 : 28;
    return MONTH_LEN[m - 4'd1];
  endfunction

  function automatic int wrap_into(input int v, input int lo, input int hi);
    int span;
    int r;
    span = hi - lo + 1;
    r = (v - lo) % span;
    if (r < 0) r += span;
    return r + lo;
  endfunction

  // Move the active field by one unit, then pull the day into the month
  function automatic void apply_unit_change(input int d);
    int v;
    int dim;
    case (cur_field)
      FIELD_YEAR: begin
        v = int'(work.year) + d;
        if (v < int'(YEAR_MIN)) v = YEAR_MIN;
        if (v > int'(YEAR_MAX)) v = YEAR_MAX;
        work.year = 12'(v);
      end
      FIELD_MONTH:  work.month  = 4'(wrap_into(int'(work.month) + d, 1, 12));
      FIELD_DAY:    work.day    = 5'(wrap_into(int'(work.day) + d, 1,
                                               days_for_month(work.year, work.month)));
      FIELD_HOUR:   work.hour   = 5'(wrap_into(int'(work.hour) + d, 0, 23));
      FIELD_MINUTE: work.minute = 6'(wrap_into(int'(work.minute) + d, 0, 59));
      FIELD_SECOND: work.second = 6'(wrap_into(int'(work.second) + d, 0, 59));
      default: ;
    endcase
    dim = days_for_month(work.year, work.month);
    if (int'(work.day) > dim) work.day = 5'(dim);
  endfunction

  function automatic void reset_editor_model();
    tpu_setting = TPU_RESET;
    edit_on     = 1'b0;
    cur_field   = FIELD_YEAR;
    tick_sum    = 0;
    work        = '{DEF_YEAR, DEF_MONTH, DEF_DAY, DEF_HOUR, DEF_MINUTE, DEF_SECOND};
  endfunction

  // Advance the predictor by one input beat and return the result beat
  function automatic dtfe_out_t predict_edit(input dtfe_in_t beat);
    dtfe_out_t res;
    int        ticks;
    int        per_unit;
    logic      done;
    ticks    = $signed(beat.steps);
    per_unit = tpu_setting;
    if (per_unit < 1) per_unit = 1;
    if (per_unit > int'(TPU_MAX)) per_unit = TPU_MAX;
    done = 1'b0;

    // Rotation counts only inside a session
    if (ticks != 0 && edit_on) begin
      tick_sum += ticks;
      while (tick_sum >= per_unit) begin
        tick_sum -= per_unit;
        apply_unit_change(1);
      end
      while (tick_sum <= -per_unit) begin
        tick_sum += per_unit;
        apply_unit_change(-1);
      end
    end

    // Button after rotation: start, advance or commit
    if (beat.button) begin
      if (!edit_on) begin
        if (beat.seed_ok)
          work = '{beat.seed_year, beat.seed_month, beat.seed_day,
                   beat.seed_hour, beat.seed_minute, beat.seed_second};
        else
          work = '{DEF_YEAR, DEF_MONTH, DEF_DAY, DEF_HOUR, DEF_MINUTE, DEF_SECOND};
        cur_field = FIELD_YEAR;
        tick_sum  = 0;
        edit_on   = 1'b1;
      end else if (cur_field == FIELD_SECOND) begin
        done    = 1'b1;
        edit_on = 1'b0;
      end else begin
        cur_field = cur_field + 3'd1;
        tick_sum  = 0;
      end
    end

    res.editing          = edit_on;
    res.active_field_out = cur_field;
    res.year_out         = work.year;
    res.month_out        = work.month;
    res.day_out          = work.day;
    res.hour_out         = work.hour;
    res.minute_out       = work.minute;
    res.second_out       = work.second;
    res.commit           = done;
    return res;
  endfunction

  // -------------------------------------------------------------------------
  // Result side: stall pattern, long hold-off and checking
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : check_results
    dtfe_out_t want;
    if (!rst && in_valid && in_stall) input_held_cycles++;
    if (!rst && out_valid && !out_stall) begin
      if (expected_edits.size() == 0) begin
        $error("result beat with no prediction waiting");
        fails++;
      end else begin
        want = expected_edits.pop_front();
        check_field("editing",          want.editing,          out_data.editing);
        check_field("active_field_out", want.active_field_out, out_data.active_field_out);
        check_field("year_out",         want.year_out,         out_data.year_out);
        check_field("month_out",        want.month_out,        out_data.month_out);
        check_field("day_out",          want.day_out,          out_data.day_out);
        check_field("hour_out",         want.hour_out,         out_data.hour_out);
        check_field("minute_out",       want.minute_out,       out_data.minute_out);
        check_field("second_out",       want.second_out,       out_data.second_out);
        check_field("commit",           want.commit,           out_data.commit);
        results_checked++;
        if (out_data.commit) commits_seen++;
      end
    end
  end

  // -------------------------------------------------------------------------
  // Input side
  // -------------------------------------------------------------------------
  // Offer one beat, idling first at random; valid stays high after the
  // accepting edge so that back-to-back beats need no second assignment
  task automatic send_edit_beat(input dtfe_in_t beat);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_edits.push_back(predict_edit(beat));
    items_sent++;
  endtask

  task automatic send_fields(input int steps, input bit press, input bit ok,
                             input int y, input int m, input int d,
                             input int h, input int mi, input int s);
    dtfe_in_t b;
    b.steps       = 6'(steps);
    b.button      = press;
    b.seed_ok     = ok;
    b.seed_year   = 12'(y);
    b.seed_month  = 4'(m);
    b.seed_day    = 5'(d);
    b.seed_hour   = 5'(h);
    b.seed_minute = 6'(mi);
    b.seed_second = 6'(s);
    send_edit_beat(b);
  endtask

  // Drop valid, wait for every prediction to be met, then let the block settle
  task automatic drain_edits();
    in_valid <= 1'b0;
    while (expected_edits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_ticks_per_unit(input logic [3:0] value);
    drain_edits();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid   <= 1'b0;
    tpu_setting = value;
  endtask

  // Mostly well-formed sessions: enter, rotate, advance, commit
  function automatic dtfe_in_t make_session_beat();
    dtfe_in_t b;
    int       roll;
    roll = $urandom_range(99);
    if (roll < 40)      b.steps = 6'($urandom);
    else if (roll < 50) b.steps = '0;
    else                b.steps = 6'(int'($urandom_range(20)) - 10);
    b.button  = edit_on ? ($urandom_range(99) < 30) : ($urandom_range(99) < 85);
    b.seed_ok = ($urandom_range(99) < 75);
    if ($urandom_range(99) < 75) begin
      b.seed_year   = 12'($urandom_range(2099, 2000));
      b.seed_month  = 4'($urandom_range(12, 1));
      b.seed_day    = 5'($urandom_range(31, 1));
      b.seed_hour   = 5'($urandom_range(23));
      b.seed_minute = 6'($urandom_range(59));
      b.seed_second = 6'($urandom_range(59));
    end else begin
      b.seed_year   = 12'($urandom);
      b.seed_month  = 4'($urandom);
      b.seed_day    = 5'($urandom);
      b.seed_hour   = 5'($urandom);
      b.seed_minute = 6'($urandom);
      b.seed_second = 6'($urandom);
    end
    return b;
  endfunction

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------
  // Walk through whole sessions at the reset tick setting
  task automatic test_directed_edits();
    // rotation outside a session is ignored
    send_fields(31, 0, 1, 2050, 6, 15, 12, 30, 30);
    // invalid seed loads the default date even with all-ones seed fields
    send_fields(-32, 1, 0, 4095, 15, 31, 31, 63, 63);
    send_fields(3, 0, 0, 0, 0, 0, 0, 0, 0);
    // year clamps at the low end
    send_fields(-32, 0, 0, 0, 0, 0, 0, 0, 0);
    // month wraps below January
    send_fields(0, 1, 0, 0, 0, 0, 0, 0, 0);
    send_fields(-2, 0, 0, 0, 0, 0, 0, 0, 0);
    // day wraps below the first
    send_fields(0, 1, 0, 0, 0, 0, 0, 0, 0);
    send_fields(-2, 0, 0, 0, 0, 0, 0, 0, 0);
    // hour and minute wrap below zero
    send_fields(0, 1, 0, 0, 0, 0, 0, 0, 0);
    send_fields(-2, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(0, 1, 0, 0, 0, 0, 0, 0, 0);
    send_fields(-2, 0, 0, 0, 0, 0, 0, 0, 0);
    // second upwards, then commit
    send_fields(0, 1, 0, 0, 0, 0, 0, 0, 0);
    send_fields(2, 0, 0, 0, 0, 0, 0, 0, 0);
    send_fields(0, 1, 0, 0, 0, 0, 0, 0, 0);
    // leap day seed; a year change pulls the day back to the 28th
    send_fields(7, 1, 1, 2024, 2, 29, 10, 20, 30);
    send_fields(2, 0, 1, 0, 0, 0, 0, 0, 0);
    send_fields(0, 1, 1, 0, 0, 0, 0, 0, 0);
    send_fields(0, 1, 1, 0, 0, 0, 0, 0, 0);
    send_fields(2, 0, 1, 0, 0, 0, 0, 0, 0);
    // advance to second and commit
    repeat (4) send_fields(0, 1, 1, 0, 0, 0, 0, 0, 0);
    // seed out of range: year clamps high, day 0 stays until edited
    send_fields(0, 1, 1, 4095, 0, 0, 31, 63, 63);
    send_fields(2, 0, 1, 0, 0, 0, 0, 0, 0);
    send_fields(1, 1, 1, 0, 0, 0, 0, 0, 0);
    send_fields(2, 0, 1, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic test_random_sessions(input int count, input logic [3:0] tpu);
    write_ticks_per_unit(tpu);
    repeat (count) send_edit_beat(make_session_beat());
  endtask

  // Hold the output off for a long stretch while beats keep coming
  task automatic test_output_hold_off();
    drain_edits();
    @(negedge clk);
    hold_req = HOLD_CYCLES;
    repeat (40) send_edit_beat(make_session_beat());
  endtask

  initial begin
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    rst       <= 1'b1;
    send_idle_pct     = 36;
    recv_idle_pct     = 71;
    hold_req          = 0;
    hold_left         = 0;
    fails             = 0;
    items_sent        = 0;
    results_checked   = 0;
    commits_seen      = 0;
    input_held_cycles = 0;
    reset_editor_model();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_edits();
    test_random_sessions(RANDOM_ITEMS, 4'd1);
    test_random_sessions(RANDOM_ITEMS, 4'd8);

    send_idle_pct = 71;
    recv_idle_pct = 36;
    test_random_sessions(RANDOM_ITEMS, 4'd0);
    test_random_sessions(RANDOM_ITEMS, 4'd15);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sessions(RANDOM_ITEMS, 4'($urandom_range(7, 3)));
    test_random_sessions(RANDOM_ITEMS, 4'($urandom_range(7, 1)));
    test_output_hold_off();

    drain_edits();
    $display("Sent %0d edit beats over tick settings 0..15; checked %0d results, %0d commits.",
             items_sent, results_checked, commits_seen);
    $display("Input was held off for %0d cycles in total.", input_held_cycles);
    if (fails == 0 && expected_edits.size() == 0) begin
      $display("tb_date_time_field_editor_top: PASS");
    end else begin
      $display("tb_date_time_field_editor_top: FAIL");
    end
    $finish;
  end

  // Abort a run that hangs
  initial begin
    #(LIMIT_NS);
    $display("tb_date_time_field_editor_top: FAIL");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/dtfe_pkg.sv
design/dtfe_step.sv
design/date_time_field_editor_top.sv
bench/tb_date_time_field_editor_top.sv
